FILE: hw/rtl/fmpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CORDIC angle constants of the FM phase discriminator.
// Used by the top level, the sequencer and the checker; depends on nothing.
package fmpd_pkg;

	localparam int TABLE_DEPTH_DEF     = 131072;
	localparam int RATIO_FRAC_BITS_DEF = 8;

	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int ACC_W    = PROD_W + 1;
	localparam int PHASE_W  = 16;

	// 4096 is a quarter of pi on the output scale
	localparam int FAST_SHIFT    = 12;
	localparam int QUO_MIN_BITS  = 13;
	localparam int MUL_LAST_STEP = 4;

	localparam logic signed [PHASE_W-1:0] PH_QUARTER = 16'sd4096;
	localparam logic signed [PHASE_W-1:0] PH_HALF    = 16'sd8192;
	localparam logic signed [PHASE_W-1:0] PH_THREE_Q = 16'sd12288;
	localparam logic signed [PHASE_W-1:0] PH_PI      = 16'sd16384;

	// CORDIC angle accumulator carries this many fraction bits below one output step
	localparam int  CORDIC_FB    = 40;
	localparam int  CORDIC_STEPS = CORDIC_FB + 4;
	localparam real ANGLE_SCALE  = 16384.0 / 3.14159;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_POST,
		ST_CORDIC,
		ST_FIN,
		ST_DONE
	} fmpd_state_t;

	typedef struct packed {
		logic take;
		logic mul;
		logic prep;
		logic div;
		logic post;
		logic cordic;
		logic fin;
		logic done;
	} fmpd_ctrl_t;

	typedef struct packed {
		logic early;
		logic ovf;
		logic run_cordic;
		logic out_free;
	} fmpd_stat_t;

	// atan(2^-i) on the output scale, with CORDIC_FB fraction bits
	function automatic longint fmpd_atan_step(input int i);
		real ang;
		ang = $atan(2.0 ** (-i));
		return longint'(ang * ANGLE_SCALE * (2.0 ** CORDIC_FB));
	endfunction

endpackage

FILE: hw/rtl/fm_phase_discriminator.sv
`timescale 1ns / 1ps
// FM phase discriminator: one input request (I, Q) gives one phase step, pi = 16384, against
// the previous sample. One item at a time: the block takes a request, works on it, and is ready
// again once the result sits in the output register. With angle_method 0 the block uses the
// rational arctangent; with angle_method 1 it uses the arctangent table, and ends early when
// the ratio truncates to zero, when the product lies on an axis or when the ratio saturates.
// A held output adds its stall before the next accept.
// The work is done by the radix-2 divider (one quotient bit a cycle, 18 steps at the default
// table depth) and, in table mode, by the 44-step CORDIC that evaluates the table entry; both
// run through the one shared shift-add unit. A result may wait in the output register while
// the next item is computed. No clearing pass after reset.
// Depends on fmpd_pkg, fmpd_alu and fmpd_seq.
module fm_phase_discriminator
	import fmpd_pkg::*;
#(
	parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
	parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [2*SAMPLE_W-1:0] s_tdata,   // sample_i [15:0], sample_q [31:16]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PHASE_W-1:0]    m_tdata,   // phase_step [15:0]
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_wdata  // angle_method
);

	localparam int K_BITS   = $clog2(TABLE_DEPTH);
	localparam int QB       = (K_BITS > QUO_MIN_BITS) ? K_BITS : QUO_MIN_BITS;
	localparam int NUM_SH   = (RATIO_FRAC_BITS > FAST_SHIFT) ? RATIO_FRAC_BITS : FAST_SHIFT;
	localparam int DIV_W    = ((NUM_SH > QB) ? (ACC_W + NUM_SH) : (ACC_W + QB)) + 1;
	localparam int MAG_BITS = (K_BITS > RATIO_FRAC_BITS) ? K_BITS : RATIO_FRAC_BITS;
	localparam int CW       = MAG_BITS + 3 + CORDIC_FB;
	localparam int W        = (DIV_W > CW) ? DIV_W : CW;
	localparam int ZW       = PHASE_W + CORDIC_FB;
	localparam int CNT_W    = $clog2(CORDIC_STEPS);

	fmpd_ctrl_t       ctrl;
	fmpd_stat_t       stat;
	logic [CNT_W-1:0] cnt;

	logic                       mode_q;
	logic signed [SAMPLE_W-1:0] cur_i_q, cur_q_q, last_i_q, last_q_q;
	logic signed [SAMPLE_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    re_q, im_q;
	logic signed [W-1:0]        x_q, y_q;
	logic signed [ZW-1:0]       z_q;
	logic [QB-1:0]              quo_q;
	logic                       num_neg_q;
	logic signed [PHASE_W-1:0]  res_q;
	logic                       m_tvalid_q;
	logic [PHASE_W-1:0]         m_tdata_q;

	logic signed [ZW-1:0] atan_tab [CORDIC_STEPS];

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
		assign atan_tab[g] = ZW'(fmpd_atan_step(g));
	end

	// Sequencer
	fmpd_seq #(
		.QUO_BITS (QB),
		.STEPS    (CORDIC_STEPS),
		.CNT_W    (CNT_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.ctrl     (ctrl),
		.cnt      (cnt)
	);

	// Shared shift-add unit
	logic                alu_sub;
	logic signed [W-1:0] alu_a_out, alu_b_out;
	logic                ge;

	assign alu_sub = ctrl.cordic ? ~y_q[W-1] : 1'b1;

	fmpd_alu #(
		.W  (W),
		.SW (CNT_W)
	) u_alu (
		.a     (y_q),
		.b     (x_q),
		.sh    (cnt),
		.sub   (alu_sub),
		.sum_a (alu_a_out),
		.sum_b (alu_b_out)
	);

	assign ge = ~alu_a_out[W-1];

	// Product operand select: i*li, q*lq, q*li, i*lq
	always_comb begin
		case (cnt[1:0])
			2'd0: begin
				mul_a = cur_i_q;
				mul_b = last_i_q;
			end
			2'd1: begin
				mul_a = cur_q_q;
				mul_b = last_q_q;
			end
			2'd2: begin
				mul_a = cur_q_q;
				mul_b = last_i_q;
			end
			default: begin
				mul_a = cur_i_q;
				mul_b = last_q_q;
			end
		endcase
	end

	// Setup of the divider and the early answers
	logic                    re_neg, im_neg, re_zero, im_zero;
	logic [ACC_W-1:0]        re_abs, im_abs, fnum_abs;
	logic signed [ACC_W:0]   re_x, ax_x, fnum, fden;
	logic [W-1:0]            prep_n, prep_d;
	logic signed [PHASE_W-1:0] early_res, sat_res;
	logic                    early;

	always_comb begin
		re_neg  = re_q[ACC_W-1];
		im_neg  = im_q[ACC_W-1];
		re_zero = (re_q == '0);
		im_zero = (im_q == '0);
		re_abs  = re_neg ? -re_q : re_q;
		im_abs  = im_neg ? -im_q : im_q;
		re_x    = (ACC_W + 1)'(re_q);
		ax_x    = signed'({1'b0, im_abs});
		if (!re_neg) begin
			fnum = re_x - ax_x;
			fden = re_x + ax_x;
		end else begin
			fnum = re_x + ax_x;
			fden = ax_x - re_x;
		end
		fnum_abs = fnum[ACC_W] ? ACC_W'(-fnum) : ACC_W'(fnum);
		prep_n = mode_q ? (W'(im_abs) << RATIO_FRAC_BITS) : (W'(fnum_abs) << FAST_SHIFT);
		prep_d = (mode_q ? W'(re_abs) : W'(fden[ACC_W-1:0])) << QB;

		if (re_zero && im_zero) early_res = '0;
		else if (re_zero)       early_res = im_neg ? -PH_HALF : PH_HALF;
		else                    early_res = re_neg ? PH_PI : '0;
		early   = (re_zero && im_zero) || (mode_q && (re_zero || im_zero));
		sat_res = im_neg ? -PH_HALF : PH_HALF;
	end

	// Quotient placement
	logic signed [PHASE_W-1:0] qs, fa, fast_res, post_res;
	logic                      k_big, k_zero, run_cordic;

	always_comb begin
		qs       = num_neg_q ? -PHASE_W'(quo_q) : PHASE_W'(quo_q);
		fa       = (re_neg ? PH_THREE_Q : PH_QUARTER) - qs;
		fast_res = im_neg ? -fa : fa;
		k_big    = ({1'b0, quo_q} >= (QB + 1)'(TABLE_DEPTH));
		k_zero   = (quo_q == '0);
		run_cordic = mode_q && !k_big && !k_zero;
		if (!mode_q)     post_res = fast_res;
		else if (k_big)  post_res = sat_res;
		else if (re_neg) post_res = im_neg ? -PH_PI : PH_PI;
		else             post_res = '0;
	end

	// Table entry from the CORDIC angle, placed by quadrant
	logic signed [PHASE_W-1:0] t_ang, fin_res;

	always_comb begin
		t_ang = PHASE_W'(z_q >>> CORDIC_FB);
		if (re_neg) fin_res = im_neg ? t_ang - PH_PI : PH_PI - t_ang;
		else        fin_res = im_neg ? -t_ang : t_ang;
	end

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	assign stat.early      = early;
	assign stat.ovf        = ge;
	assign stat.run_cordic = run_cordic;
	assign stat.out_free   = out_free;

	// Control state and kept sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			last_i_q   <= '0;
			last_q_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata[0];
			if (ctrl.prep) begin
				last_i_q <= cur_i_q;
				last_q_q <= cur_q_q;
			end
			if (ctrl.done && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready)         m_tvalid_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (ctrl.take && s_tvalid) begin
			cur_i_q <= s_tdata[SAMPLE_W-1:0];
			cur_q_q <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
		end

		if (ctrl.mul) begin
			prod_q <= mul_a * mul_b;
			case (cnt[2:0])
				3'd1:    re_q <= ACC_W'(prod_q);
				3'd2:    re_q <= re_q + ACC_W'(prod_q);
				3'd3:    im_q <= ACC_W'(prod_q);
				3'd4:    im_q <= im_q - ACC_W'(prod_q);
				default: ;
			endcase
		end

		if (ctrl.prep) begin
			y_q       <= prep_n;
			x_q       <= prep_d;
			num_neg_q <= fnum[ACC_W];
			res_q     <= early_res;
		end

		if (ctrl.div) begin
			if (cnt == '0) begin
				// quotient at or above 2^QB: beyond the table
				if (ge) res_q <= sat_res;
			end else begin
				quo_q <= {quo_q[QB-2:0], ge};
				if (ge) y_q <= alu_a_out;
			end
		end

		if (ctrl.post) begin
			res_q <= post_res;
			x_q   <= W'(1) << (RATIO_FRAC_BITS + CORDIC_FB);
			y_q   <= W'(quo_q) << CORDIC_FB;
			z_q   <= '0;
		end

		if (ctrl.cordic) begin
			y_q <= alu_a_out;
			x_q <= alu_b_out;
			z_q <= alu_sub ? z_q + atan_tab[cnt] : z_q - atan_tab[cnt];
		end

		if (ctrl.fin) res_q <= fin_res;

		if (ctrl.done && out_free) m_tdata_q <= res_q;
	end

	assign s_tready = ctrl.take;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: hw/rtl/fmpd_alu.sv
`timescale 1ns / 1ps
// Shared shift-add unit: one radix-2 divider step or one CORDIC rotation per cycle.
// Stand-alone; driven by the top level datapath registers.
module fmpd_alu #(
	parameter int W  = 60,
	parameter int SW = 6
) (
	input  logic signed [W-1:0]  a,
	input  logic signed [W-1:0]  b,
	input  logic        [SW-1:0] sh,
	input  logic                 sub,
	output logic signed [W-1:0]  sum_a,
	output logic signed [W-1:0]  sum_b
);

	logic signed [W-1:0] a_sh;
	logic signed [W-1:0] b_sh;

	assign a_sh = a >>> sh;
	assign b_sh = b >>> sh;

	// cross update: a and b each move by the other's shifted value, in opposite directions; sub sets which way
	assign sum_a = sub ? a - b_sh : a + b_sh;
	assign sum_b = sub ? b + a_sh : b - a_sh;

endmodule

FILE: hw/rtl/fmpd_seq.sv
`timescale 1ns / 1ps
// Sequencer of the FM phase discriminator: state register, step counter, control decode.
// Depends on fmpd_pkg for the state enum and the control and status structs.
module fmpd_seq
	import fmpd_pkg::*;
#(
	parameter int QUO_BITS = QUO_MIN_BITS,
	parameter int STEPS    = CORDIC_STEPS,
	parameter int CNT_W    = $clog2(CORDIC_STEPS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  fmpd_stat_t       stat,
	output fmpd_ctrl_t       ctrl,
	output logic [CNT_W-1:0] cnt
);

	fmpd_state_t      state_q;
	fmpd_state_t      state_d;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == CNT_W'(MUL_LAST_STEP)) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = stat.early ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0 && stat.ovf) state_d = ST_DONE;
				else if (cnt_q == CNT_W'(QUO_BITS)) state_d = ST_POST;
			end
			ST_POST: begin
				state_d = stat.run_cordic ? ST_CORDIC : ST_DONE;
			end
			ST_CORDIC: begin
				if (cnt_q == CNT_W'(STEPS - 1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE:   ctrl.take   = 1'b1;
			ST_MUL:    ctrl.mul    = 1'b1;
			ST_PREP:   ctrl.prep   = 1'b1;
			ST_DIV:    ctrl.div    = 1'b1;
			ST_POST:   ctrl.post   = 1'b1;
			ST_CORDIC: ctrl.cordic = 1'b1;
			ST_FIN:    ctrl.fin    = 1'b1;
			ST_DONE:   ctrl.done   = 1'b1;
			default:   ctrl        = '0;
		endcase
	end

	assign cnt = cnt_q;

endmodule

FILE: hw/rtl/fmpd_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the FM phase discriminator, bound to the top level.
// Depends on fmpd_pkg for the phase scale.
module fmpd_checker
	import fmpd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [PHASE_W-1:0] m_tdata
);

	// hold off new requests while the products are formed
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready
			##1 !s_tready)
		else $error("input taken again while an item is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed or dropped");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (($signed(m_tdata) >= -PH_PI) && ($signed(m_tdata) <= PH_PI)))
		else $error("phase step outside plus or minus pi");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while the block was idle");

endmodule

bind fm_phase_discriminator fmpd_checker u_fmpd_checker (.*);
